/* rtl/rlp_pkg.sv */
package rlp_pkg;

	localparam int LEN_BYTES = 4;

	localparam logic [31:0] LEN_CAP = (LEN_BYTES >= 4) ? 32'hFFFF_FFFF :
		32'((64'd1 << (8 * LEN_BYTES)) - 64'd1);

	localparam logic [7:0] STR_OFFSET  = 8'h80;
	localparam logic [7:0] LIST_OFFSET = 8'hC0;
	localparam logic [7:0] SHORT_MAX   = 8'd55;
	localparam logic [7:0] SINGLE_HDR  = 8'h81;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_STR  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_LIST = 2'd2,
		KIND_INT  = 2'd3
	} rlp_kind_t;

	// One queued job: a leading byte followed by nb bytes taken from the top of val.
	typedef struct packed {
		logic [7:0]  first;
		logic [3:0]  nb;
		logic [63:0] val;
	} rlp_job_t;

	function automatic logic [3:0] byte_count(input logic [63:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[8*i +: 8] != 8'd0) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

	// Moves the nb low bytes of v to the top of the word.
	function automatic logic [63:0] align_top(input logic [63:0] v, input logic [3:0] nb);
		logic [3:0] rest;
		logic [5:0] sh;
		rest = 4'd8 - nb;
		sh = {rest[2:0], 3'b000};
		return v << sh;
	endfunction

endpackage

/* rtl/rlp_front.sv */
module rlp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [31:0]       length,
	input  logic [63:0]       int_value,
	input  logic [7:0]        data_byte,
	input  logic              q_ready,
	output logic              push,
	output rlp_pkg::rlp_job_t job
);

	logic        pending_q;
	logic        pending_d;
	logic        has_out;
	logic [31:0] len_c;
	logic [3:0]  nb_len;
	logic [3:0]  nb_int;
	logic [7:0]  offset;
	logic        accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept && has_out;

	assign len_c  = (length > rlp_pkg::LEN_CAP) ? rlp_pkg::LEN_CAP : length;
	assign nb_len = rlp_pkg::byte_count({32'd0, len_c});
	assign nb_int = rlp_pkg::byte_count(int_value);
	assign offset = (rlp_pkg::rlp_kind_t'(kind) == rlp_pkg::KIND_LIST) ?
		rlp_pkg::LIST_OFFSET : rlp_pkg::STR_OFFSET;

	always_comb begin
		job       = '0;
		has_out   = 1'b1;
		pending_d = 1'b0;
		unique case (rlp_pkg::rlp_kind_t'(kind))
			rlp_pkg::KIND_DATA: begin
				if (pending_q && data_byte[7]) begin
					job.first = rlp_pkg::SINGLE_HDR;
					job.nb    = 4'd1;
					job.val   = {data_byte, 56'd0};
				end else begin
					job.first = data_byte;
				end
			end
			rlp_pkg::KIND_STR, rlp_pkg::KIND_LIST: begin
				if (rlp_pkg::rlp_kind_t'(kind) == rlp_pkg::KIND_STR && len_c == 32'd1) begin
					has_out   = 1'b0;
					pending_d = 1'b1;
				end else if (len_c <= 32'(rlp_pkg::SHORT_MAX)) begin
					job.first = offset + len_c[7:0];
				end else begin
					job.first = offset + rlp_pkg::SHORT_MAX + {4'd0, nb_len};
					job.nb    = nb_len;
					job.val   = rlp_pkg::align_top({32'd0, len_c}, nb_len);
				end
			end
			rlp_pkg::KIND_INT: begin
				if (nb_int == 4'd1 && !int_value[7]) begin
					job.first = int_value[7:0];
				end else begin
					job.first = rlp_pkg::STR_OFFSET + {4'd0, nb_int};
					job.nb    = nb_int;
					job.val   = rlp_pkg::align_top(int_value, nb_int);
				end
			end
			default: begin
				has_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= pending_d;
		end
	end

endmodule

/* rtl/rlp_queue.sv */
module rlp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rlp_pkg::rlp_job_t push_job,
	output logic              push_ready,
	input  logic              pop,
	output logic              pop_valid,
	output rlp_pkg::rlp_job_t pop_job
);

	rlp_pkg::rlp_job_t               mem_q [rlp_pkg::QUEUE_DEPTH];
	logic [rlp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [rlp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [rlp_pkg::QCNT_W-1:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = count_q != rlp_pkg::QCNT_W'(rlp_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + rlp_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + rlp_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + rlp_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - rlp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/rlp_back.sv */
module rlp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  rlp_pkg::rlp_job_t q_job,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              last
);

	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [3:0]  rem_q;
	logic [63:0] val_q;
	logic        load;

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;
	assign load      = !valid_q || out_ready;
	assign pop       = load && (rem_q == 4'd0) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 4'd0;
		end else if (load) begin
			if (rem_q != 4'd0) begin
				valid_q <= 1'b1;
				rem_q   <= rem_q - 4'd1;
			end else if (q_valid) begin
				valid_q <= 1'b1;
				rem_q   <= q_job.nb;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (rem_q != 4'd0) begin
				byte_q <= val_q[63:56];
				last_q <= rem_q == 4'd1;
				val_q  <= {val_q[55:0], 8'd0};
			end else if (q_valid) begin
				byte_q <= q_job.first;
				last_q <= q_job.nb == 4'd0;
				val_q  <= q_job.val;
			end
		end
	end

endmodule

/* rtl/rlp_stream_encoder_top.sv */
// Channel  Direction  Payload
// s_*      in         tuser: kind; tdata: length, int_value, data_byte
// m_*      out        tdata: out_byte; tlast: last
//
// An item that makes one byte passes at one per cycle while m_tready is high; an item with
// n bytes sends them one byte a cycle, while m_tready is high, from the output stage's shift register.
// A four-entry job queue lets the input keep accepting while the output stalls.
// Reset is asynchronous and clears the pending flag, the queue and the output stage.
// The input stalls only when the job queue is full.
module rlp_stream_encoder_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] length, [95:32] int_value, [103:96] data_byte.
	input  logic [103:0] s_tdata,
	// [1:0] kind.
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] out_byte.
	output logic [7:0]   m_tdata,
	output logic         m_tlast
);

	rlp_pkg::rlp_job_t push_job;
	rlp_pkg::rlp_job_t pop_job;
	logic              push;
	logic              push_ready;
	logic              pop;
	logic              pop_valid;

	rlp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.kind      (s_tuser),
		.length    (s_tdata[31:0]),
		.int_value (s_tdata[95:32]),
		.data_byte (s_tdata[103:96]),
		.q_ready   (push_ready),
		.push      (push),
		.job       (push_job)
	);

	rlp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	rlp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_job     (pop_job),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.last      (m_tlast)
	);

endmodule
